>>> hdl/magic_square_block_transposition_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the magic-square block transposition block.
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAGIC_SQUARE_BLOCK_TRANSPOSITION_MACROS_SVH
`define MAGIC_SQUARE_BLOCK_TRANSPOSITION_MACROS_SVH

// Same-cycle implication.
`define MSBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msbt assertion failed");

// Next-cycle implication.
`define MSBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msbt assertion failed");

`endif

>>> hdl/msbt_pkg.sv
// ----------------------------------------------------------------------------
// msbt_pkg
// Shared types and constants of the magic-square block transposition block.
// ----------------------------------------------------------------------------
`default_nettype none

package msbt_pkg;

  localparam int ACTION_W = 2;
  localparam int CELLS_W  = 6;
  localparam int VAL_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int SIDE_W   = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [ACTION_W-1:0] ACT_TABLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TEXT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_END   = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd5;
  localparam logic [BYTE_W-1:0] PAD_CHAR   = 8'h2E;
  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;

  // Write and read requests for the table and text memories.
  typedef struct packed {
    logic               perm_we;
    logic [CELLS_W-1:0] perm_waddr;
    logic [VAL_W-1:0]   perm_wdata;
    logic               text_we;
    logic [CELLS_W-1:0] text_waddr;
    logic [BYTE_W-1:0]  text_wdata;
    logic               rd_en;
    logic [CELLS_W-1:0] perm_raddr;
    logic [CELLS_W-1:0] text_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hdl/msbt_ifs.sv
// ----------------------------------------------------------------------------
// msbt channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface msbt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [msbt_pkg::ACTION_W-1:0]        action;
  logic [msbt_pkg::CELLS_W-1:0]         table_index;
  logic [msbt_pkg::VAL_W-1:0]           table_value;
  logic [msbt_pkg::BYTE_W-1:0]          text_byte;

  modport source (output valid, action, table_index, table_value, text_byte,
                  input ready);
  modport sink   (input valid, action, table_index, table_value, text_byte,
                  output ready);
endinterface

interface msbt_out_if;
  logic                        valid;
  logic                        ready;
  logic [msbt_pkg::BYTE_W-1:0] cipher_byte;
  logic                        last;

  modport source (output valid, cipher_byte, last, input ready);
  modport sink   (input valid, cipher_byte, last, output ready);
endinterface

`default_nettype wire

>>> hdl/msbt_store.sv
// ----------------------------------------------------------------------------
// msbt_store
// Permutation table and text buffer memories with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msbt_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire msbt_pkg::mem_req_t          req,
  output logic [msbt_pkg::VAL_W-1:0]       perm_rd,
  output logic [msbt_pkg::BYTE_W-1:0]      text_rd
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [msbt_pkg::VAL_W-1:0]  perm_mem [DEPTH];
  logic [msbt_pkg::BYTE_W-1:0] text_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.perm_we) begin
      perm_mem[req.perm_waddr[IDX_W-1:0]] <= req.perm_wdata;
    end
    if (req.rd_en) begin
      perm_rd <= perm_mem[req.perm_raddr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.text_we) begin
      text_mem[req.text_waddr[IDX_W-1:0]] <= req.text_wdata;
    end
    if (req.rd_en) begin
      text_rd <= text_mem[req.text_raddr[IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> hdl/magic_square_block_transposition.sv
// ----------------------------------------------------------------------------
// magic_square_block_transposition
// Block transposition cipher keyed by a square permutation table.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Moves
//   in_ch    sink       one item: table write, text byte or end of block
//   out_ch   source     one item per cipher byte, last marks the block end
//   cfg_*    APB slave  side register at byte address 0
//
// Table writes and text bytes are taken back to back while no block is emitted.
// An end item emits side*side bytes at one per cycle while out_ch does not
// stall; the first byte passes the emit state, the two chained memory reads
// and the output register. The next input item is taken only once the last
// table read of the block has left the first stage.
// Reset is synchronous and active low; the memories are not cleared.
// A stall on out_ch freezes the whole read pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magic_square_block_transposition_macros.svh"

module magic_square_block_transposition #(
  parameter int MAX_SIDE = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  msbt_in_if.sink                            in_ch,
  msbt_out_if.source                         out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [msbt_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [msbt_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic      [msbt_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  // Both memories hold one block; cells past the largest block are never read.
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = msbt_pkg::SIDE_W;
  localparam int VW    = msbt_pkg::VAL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Configuration register. The register sits at address 0; addresses with
  // bit 2 set lie past the register list and are ignored.
  logic [SW-1:0] side_r, side_nxt;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && !cfg_paddr[2];
  assign side_nxt   = cfg_wr ? cfg_pwdata[SW-1:0] : side_r;
  assign cfg_prdata = cfg_paddr[2] ? '0 : msbt_pkg::APB_DW'(side_r);

  // Effective side saturates to 1..MAX_SIDE, and the block size follows.
  logic [SW-1:0]   side_eff;
  logic [2*SW-1:0] side_sq;
  logic [CNT_W-1:0] total;

  always_comb begin
    if (side_r == '0) begin
      side_eff = SW'(1);
    end else if (side_r > SW'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  assign side_sq = {{SW{1'b0}}, side_eff} * {{SW{1'b0}}, side_eff};
  assign total   = CNT_W'(side_sq);

  // Control state.
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;

  // Read pipeline: the first stage holds table data, the second text data,
  // then the output register.
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r, s1_last_nxt;
  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_last_r, s2_last_nxt;
  logic             s2_blank_r, s2_blank_nxt;
  logic             s2_pad_r, s2_pad_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [msbt_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             advance;
  logic             accept;
  logic             emit_last;
  logic             text_we;
  logic             table_in_range;
  logic [VW-1:0]    pos;

  msbt_pkg::mem_req_t          mem_req;
  logic [VW-1:0]               perm_rd;
  logic [msbt_pkg::BYTE_W-1:0] text_rd;

  assign in_ch.ready = (state_r == ST_IDLE) && !s1_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // The whole pipeline moves only when the output register can take a byte.
  assign advance   = !out_valid_r || out_ch.ready;
  assign emit_last = (emit_idx_r == (total - CNT_W'(1)));

  assign table_in_range = ({1'b0, in_ch.table_index} < VW'(DEPTH));
  assign text_we = accept && (in_ch.action == msbt_pkg::ACT_TEXT)
                   && (byte_count_r < total);

  // Source position of the cell that the first stage holds. Only cells
  // within the block are used for a text read, so the index fits.
  assign pos = perm_rd - VW'(1);

  always_comb begin
    mem_req            = '0;
    mem_req.perm_we    = accept && (in_ch.action == msbt_pkg::ACT_TABLE)
                         && table_in_range;
    mem_req.perm_waddr = in_ch.table_index;
    mem_req.perm_wdata = in_ch.table_value;
    mem_req.text_we    = text_we;
    mem_req.text_waddr = msbt_pkg::CELLS_W'(byte_count_r[IDX_W-1:0]);
    mem_req.text_wdata = in_ch.text_byte;
    mem_req.rd_en      = advance;
    mem_req.perm_raddr = msbt_pkg::CELLS_W'(emit_idx_r[IDX_W-1:0]);
    mem_req.text_raddr = msbt_pkg::CELLS_W'(pos[IDX_W-1:0]);
  end

  msbt_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .perm_rd (perm_rd),
    .text_rd (text_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    emit_idx_nxt   = emit_idx_r;
    byte_count_nxt = byte_count_r;

    s1_valid_nxt  = s1_valid_r;
    s1_last_nxt   = s1_last_r;
    s2_valid_nxt  = s2_valid_r;
    s2_last_nxt   = s2_last_r;
    s2_blank_nxt  = s2_blank_r;
    s2_pad_nxt    = s2_pad_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.action == msbt_pkg::ACT_END)) begin
          state_nxt    = ST_EMIT;
          emit_idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (text_we) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end

    if (advance) begin
      // Table read is issued for the current cell while emitting.
      s1_valid_nxt = (state_r == ST_EMIT);
      s1_last_nxt  = emit_last;

      // Classify the cell: outside 1..total gives a space, a position past
      // the received text gives padding.
      s2_valid_nxt = s1_valid_r;
      s2_last_nxt  = s1_last_r;
      s2_blank_nxt = (perm_rd == '0) || (perm_rd > VW'(total));
      s2_pad_nxt   = (perm_rd > VW'(byte_count_r));

      out_valid_nxt = s2_valid_r;
      out_last_nxt  = s2_last_r;
      if (s2_blank_r) begin
        out_byte_nxt = msbt_pkg::BLANK_CHAR;
      end else if (s2_pad_r) begin
        out_byte_nxt = msbt_pkg::PAD_CHAR;
      end else begin
        out_byte_nxt = text_rd;
      end

      // The count is needed until the last cell has been classified.
      if (s1_valid_r && s1_last_r) begin
        byte_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= msbt_pkg::SIDE_RESET;
      state_r      <= ST_IDLE;
      emit_idx_r   <= '0;
      byte_count_r <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      side_r       <= side_nxt;
      state_r      <= state_nxt;
      emit_idx_r   <= emit_idx_nxt;
      byte_count_r <= byte_count_nxt;
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r  <= s1_last_nxt;
    s2_last_r  <= s2_last_nxt;
    s2_blank_r <= s2_blank_nxt;
    s2_pad_r   <= s2_pad_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_byte = out_byte_r;
  assign out_ch.last        = out_last_r;

  // The text buffer must not change while its reads are still in flight.
  `MSBT_ASSERT_IMP(a_no_text_write_in_emit, (state_r == ST_EMIT) || s1_valid_r, !text_we)
  // The emit counter stays inside the block.
  `MSBT_ASSERT_IMP(a_emit_idx_in_block, state_r == ST_EMIT, emit_idx_r < total)
  // Once the last cell leaves the first stage, no further read is issued.
  `MSBT_ASSERT_NXT(a_single_last, s1_valid_r && s1_last_r && advance, !s1_valid_r)

endmodule

`default_nettype wire
